/* rtl/lfsa_pkg.sv */
// ----------------------------------------------------------------------------
// Lowest free slot allocator package
// Sizes, the control state encoding and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsa_pkg;

    localparam int STALLS     = 64;
    localparam int TIME_W     = 16;
    localparam int ID_W       = 10;
    localparam int SLOT_OUT_W = 7;
    localparam int PEAK_OUT_W = 7;
    localparam int CNT_W      = $clog2(STALLS + 1);
    localparam int GRP        = 8;
    localparam int NGRP       = (STALLS + GRP - 1) / GRP;
    localparam int PART_W     = $clog2(GRP + 1);

    typedef logic [TIME_W-1:0] t_time;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_REL  = 4'b0010,
        ST_PICK = 4'b0100,
        ST_SUM  = 4'b1000
    } t_state;

    typedef struct packed {
        logic rel_en;
        logic pick_en;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/lfsa_if.sv */
// ----------------------------------------------------------------------------
// Lowest free slot allocator channels
// Request and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfsa_req_if;
    logic                      valid;
    logic                      ready;
    logic [lfsa_pkg::TIME_W-1:0] start_time;
    logic [lfsa_pkg::TIME_W-1:0] end_time;
    logic [lfsa_pkg::ID_W-1:0]   request_id;

    modport source (output valid, output start_time, output end_time,
                    output request_id, input ready);
    modport sink   (input valid, input start_time, input end_time,
                    input request_id, output ready);
endinterface

interface lfsa_res_if;
    logic                            valid;
    logic                            ready;
    logic [lfsa_pkg::ID_W-1:0]       echo_id;
    logic [lfsa_pkg::SLOT_OUT_W-1:0] assigned_slot;
    logic                            overflow;
    logic [lfsa_pkg::PEAK_OUT_W-1:0] peak_slots;

    modport source (output valid, output echo_id, output assigned_slot,
                    output overflow, output peak_slots, input ready);
    modport sink   (input valid, input echo_id, input assigned_slot,
                    input overflow, input peak_slots, output ready);
endinterface

`default_nettype wire

/* rtl/lfsa_cell.sv */
// ----------------------------------------------------------------------------
// Lowest free slot allocator cell
// Holds one slot's busy flag and end time, releases the slot when its end
// lies below the new start, and claims it when no lower slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsa_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lfsa_pkg::t_cell_ctl i_ctl,
    input  wire lfsa_pkg::t_time     i_start,
    input  wire lfsa_pkg::t_time     i_end,
    input  wire logic                i_free_below,
    output logic                     o_free_below,
    output logic                     o_grant,
    output logic                     o_busy
);

    logic            r_busy;
    lfsa_pkg::t_time r_end;

    assign o_free_below = i_free_below | ~r_busy;
    assign o_grant      = i_ctl.pick_en & ~r_busy & ~i_free_below;
    assign o_busy       = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.rel_en && r_busy && (r_end < i_start)) begin
            r_busy <= 1'b0;
        end else if (o_grant) begin
            r_busy <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_grant) begin
            r_end <= i_end;
        end
    end

endmodule

`default_nettype wire

/* rtl/lowest_free_slot_interval_allocator.sv */
// ----------------------------------------------------------------------------
// Lowest free slot interval allocator
// Greedy interval partitioning over a row of slot cells.
// ----------------------------------------------------------------------------
// Requests (start_time, end_time, request_id) arrive on i_req in nondecreasing
// start order. Each request gives one result on o_res: its id, the slot it
// took (1 based, 0 with overflow set when every slot is busy) and the running
// peak of slots busy at once.
// A request is taken only when the allocator is idle. After a transfer the
// row of cells releases finished slots in the release state, the free-slot
// chain picks the lowest free cell in the pick state, and the sum state adds
// up the busy count for the peak and loads the output register. No new
// request is taken until the allocator is back in idle; the busy count
// summation is its last step.
// The result sits in an output register, so the next request is taken while
// it waits. If the receiver stalls with a result still held, the summing step
// waits until the output register frees up.
// Reset clears every slot to free, the peak to zero and the result valid, and
// leaves the request channel ready.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_free_slot_interval_allocator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lfsa_req_if.sink  i_req,
    lfsa_res_if.source o_res
);

    lfsa_pkg::t_state    r_state;
    lfsa_pkg::t_state    n_state;
    lfsa_pkg::t_cell_ctl w_ctl;

    lfsa_pkg::t_time             r_start;
    lfsa_pkg::t_time             r_end;
    logic [lfsa_pkg::ID_W-1:0]   r_id;

    logic [lfsa_pkg::STALLS:0]     w_chain;
    logic [lfsa_pkg::STALLS-1:0]   w_grant;
    logic [lfsa_pkg::STALLS-1:0]   w_busy;

    logic [lfsa_pkg::PART_W-1:0]     r_part [lfsa_pkg::NGRP];
    logic [lfsa_pkg::PART_W-1:0]     n_part [lfsa_pkg::NGRP];
    logic                            r_found;
    logic [lfsa_pkg::SLOT_OUT_W-1:0] r_slot;
    logic [lfsa_pkg::SLOT_OUT_W-1:0] n_slot;

    logic [lfsa_pkg::CNT_W-1:0] r_peak;
    logic [lfsa_pkg::CNT_W-1:0] n_peak;
    logic [lfsa_pkg::CNT_W-1:0] w_total;

    logic                            r_out_valid;
    logic [lfsa_pkg::ID_W-1:0]       r_out_id;
    logic [lfsa_pkg::SLOT_OUT_W-1:0] r_out_slot;
    logic                            r_out_ovf;
    logic [lfsa_pkg::PEAK_OUT_W-1:0] r_out_peak;

    logic w_in_xfer;
    logic w_out_free;

    assign i_req.ready = (r_state == lfsa_pkg::ST_IDLE);
    assign w_in_xfer   = i_req.valid & i_req.ready;
    assign w_out_free  = ~r_out_valid | o_res.ready;

    assign w_ctl.rel_en  = (r_state == lfsa_pkg::ST_REL);
    assign w_ctl.pick_en = (r_state == lfsa_pkg::ST_PICK);

    assign w_chain[0] = 1'b0;

    for (genvar g_i = 0; g_i < lfsa_pkg::STALLS; g_i++) begin : g_cell
        lfsa_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_start      (r_start),
            .i_end        (r_end),
            .i_free_below (w_chain[g_i]),
            .o_free_below (w_chain[g_i+1]),
            .o_grant      (w_grant[g_i]),
            .o_busy       (w_busy[g_i])
        );
    end

    always_comb begin
        n_slot = '0;
        for (int i = 0; i < lfsa_pkg::STALLS; i++) begin
            if (w_grant[i]) begin
                n_slot = n_slot | lfsa_pkg::SLOT_OUT_W'(i + 1);
            end
        end
    end

    always_comb begin
        for (int g = 0; g < lfsa_pkg::NGRP; g++) begin
            n_part[g] = '0;
            for (int k = 0; k < lfsa_pkg::GRP; k++) begin
                if (g * lfsa_pkg::GRP + k < lfsa_pkg::STALLS) begin
                    n_part[g] = n_part[g]
                              + lfsa_pkg::PART_W'(w_busy[g * lfsa_pkg::GRP + k]);
                end
            end
        end
    end

    always_comb begin
        w_total = lfsa_pkg::CNT_W'(r_found);
        for (int g = 0; g < lfsa_pkg::NGRP; g++) begin
            w_total = w_total + lfsa_pkg::CNT_W'(r_part[g]);
        end
        n_peak = (r_found && (w_total > r_peak)) ? w_total : r_peak;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfsa_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = lfsa_pkg::ST_REL;
                end
            end
            lfsa_pkg::ST_REL: begin
                n_state = lfsa_pkg::ST_PICK;
            end
            lfsa_pkg::ST_PICK: begin
                n_state = lfsa_pkg::ST_SUM;
            end
            lfsa_pkg::ST_SUM: begin
                if (w_out_free) begin
                    n_state = lfsa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lfsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfsa_pkg::ST_IDLE;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lfsa_pkg::ST_SUM && w_out_free) begin
                r_peak      <= n_peak;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_start <= i_req.start_time;
            r_end   <= i_req.end_time;
            r_id    <= i_req.request_id;
        end
        if (r_state == lfsa_pkg::ST_PICK) begin
            r_found <= w_chain[lfsa_pkg::STALLS];
            r_slot  <= n_slot;
            for (int g = 0; g < lfsa_pkg::NGRP; g++) begin
                r_part[g] <= n_part[g];
            end
        end
        if (r_state == lfsa_pkg::ST_SUM && w_out_free) begin
            r_out_id   <= r_id;
            r_out_slot <= r_slot;
            r_out_ovf  <= ~r_found;
            r_out_peak <= lfsa_pkg::PEAK_OUT_W'(n_peak);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.echo_id       = r_out_id;
    assign o_res.assigned_slot = r_out_slot;
    assign o_res.overflow      = r_out_ovf;
    assign o_res.peak_slots    = r_out_peak;

`ifndef SYNTHESIS
    a_one_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_grant))
        else $error("more than one slot claimed in one cycle");

    a_grant_only_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lfsa_pkg::ST_PICK) |-> (w_grant == '0))
        else $error("slot claimed outside the pick cycle");

    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_peak >= $past(r_peak)))
        else $error("peak count decreased");

    a_xfer_starts_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == lfsa_pkg::ST_REL))
        else $error("input transfer did not start a release cycle");
`endif

endmodule

`default_nettype wire
